@@ rtl/rrfp_pkg.sv @@
// rrfp_pkg: shared constants, frame layout and the front-to-back event type
// for the radar report frame parser
// no dependencies
package rrfp_pkg;

   // default frame buffer size in bytes
   localparam int FRAME_BYTES_DEFAULT = 64;

   // depth of the event queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // header and footer patterns
   localparam logic [7:0] HDR_0 = 8'hF4;
   localparam logic [7:0] HDR_1 = 8'hF3;
   localparam logic [7:0] HDR_2 = 8'hF2;
   localparam logic [7:0] HDR_3 = 8'hF1;
   localparam logic [7:0] FTR_0 = 8'hF8;
   localparam logic [7:0] FTR_1 = 8'hF7;
   localparam logic [7:0] FTR_2 = 8'hF6;
   localparam logic [7:0] FTR_3 = 8'hF5;

   // payload markers and types
   localparam logic [7:0] MARK_HEAD = 8'hAA;
   localparam logic [7:0] MARK_TAIL = 8'h55;
   localparam logic [7:0] TYPE_ENG  = 8'h01;
   localparam logic [7:0] TYPE_STD  = 8'h02;

   // length rules
   localparam int MIN_PAYLOAD    = 11;
   localparam int WIDE_PAYLOAD   = 41;
   localparam int FRAME_OVERHEAD = 10;
   localparam int HEADER_BYTES   = 4;

   // byte positions within the frame
   localparam int POS_LEN_LO = 4;
   localparam int POS_LEN_HI = 5;
   localparam int POS_TYPE   = 6;
   localparam int POS_HEAD   = 7;
   localparam int POS_STATE  = 8;
   localparam int POS_MD_LO  = 9;
   localparam int POS_MD_HI  = 10;
   localparam int POS_ME     = 11;
   localparam int POS_SD_LO  = 12;
   localparam int POS_SD_HI  = 13;
   localparam int POS_SE     = 14;
   localparam int POS_MGATE  = 15;
   localparam int POS_SGATE  = 16;
   localparam int POS_LIGHT  = 45;

   // header byte expected at a given position
   function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = HDR_0;
         2'd1:    val = HDR_1;
         2'd2:    val = HDR_2;
         default: val = HDR_3;
      endcase
      return val;
   endfunction

   // one classified frame handed from front to back
   typedef struct packed {
      logic        rejected;
      logic        eng;
      logic        wide;
      logic [7:0]  state;
      logic [15:0] md;
      logic [7:0]  me;
      logic [15:0] sd;
      logic [7:0]  se;
      logic [7:0]  mgate;
      logic [7:0]  sgate;
      logic [7:0]  light;
   } event_type;

endpackage

@@ rtl/rrfp_front.sv @@
// rrfp_front: byte framer, hunts the header, tracks position, captures report
// fields and classifies each finished frame as good or rejected
// depends on rrfp_pkg
module rrfp_front #(
   parameter int FRAME_BYTES = rrfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  queue_full,
   output logic                  ev_valid,
   output rrfp_pkg::event_type   ev_data
);

   localparam int PW = $clog2(FRAME_BYTES + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(FRAME_BYTES);
   localparam logic [16:0]   LEN_LIMIT = 17'(FRAME_BYTES);
   localparam logic [PW-1:0] WIDE_LEN  =
      PW'(rrfp_pkg::WIDE_PAYLOAD + rrfp_pkg::FRAME_OVERHEAD);

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] exp_ff, exp_in;
   logic [7:0]    len_lo_ff, len_lo_in;
   logic          type_ok_ff, type_ok_in;
   logic          eng_ff, eng_in;
   logic          head_ok_ff, head_ok_in;
   logic          mark_ok_ff, mark_ok_in;
   logic          foot_ok_ff, foot_ok_in;
   rrfp_pkg::event_type cap_ff, cap_in;

   logic          accept;
   logic [15:0]   plen;
   logic [16:0]   plen_total;
   logic          frame_ok;

   assign req_stall = queue_full;

   // framing and classification
   always_comb begin
      accept      = req_valid & ~queue_full;
      pos_in      = pos_ff;
      exp_in      = exp_ff;
      len_lo_in   = len_lo_ff;
      type_ok_in  = type_ok_ff;
      eng_in      = eng_ff;
      head_ok_in  = head_ok_ff;
      mark_ok_in  = mark_ok_ff;
      foot_ok_in  = foot_ok_ff;
      cap_in      = cap_ff;
      ev_valid    = 1'b0;
      ev_data     = cap_ff;
      plen        = {req_rx_byte, len_lo_ff};
      plen_total  = {1'b0, plen} + 17'(rrfp_pkg::FRAME_OVERHEAD);
      frame_ok    = foot_ok_ff & (req_rx_byte == rrfp_pkg::FTR_3) & type_ok_ff &
                    head_ok_ff & mark_ok_ff;
      if (accept) begin
         if (pos_ff < PW'(rrfp_pkg::HEADER_BYTES)) begin
            // header hunt
            exp_in = '0;
            if (req_rx_byte == rrfp_pkg::hdr_byte(pos_ff[1:0])) begin
               pos_in = pos_ff + PW'(1);
            end else if (req_rx_byte == rrfp_pkg::HDR_0) begin
               pos_in = PW'(1);
            end else begin
               pos_in = '0;
            end
         end else if (pos_ff >= POS_LIMIT) begin
            // buffer overrun, reject and rehunt with this byte
            ev_valid         = 1'b1;
            ev_data.rejected = 1'b1;
            exp_in           = '0;
            pos_in           = (req_rx_byte == rrfp_pkg::HDR_0) ? PW'(1) : '0;
         end else begin
            pos_in = pos_ff + PW'(1);

            // field capture by position
            case (pos_ff)
               PW'(rrfp_pkg::POS_LEN_LO): len_lo_in = req_rx_byte;
               PW'(rrfp_pkg::POS_TYPE): begin
                  type_ok_in = (req_rx_byte == rrfp_pkg::TYPE_ENG) ||
                               (req_rx_byte == rrfp_pkg::TYPE_STD);
                  eng_in     = (req_rx_byte == rrfp_pkg::TYPE_ENG);
               end
               PW'(rrfp_pkg::POS_HEAD):  head_ok_in      = (req_rx_byte == rrfp_pkg::MARK_HEAD);
               PW'(rrfp_pkg::POS_STATE): cap_in.state    = req_rx_byte;
               PW'(rrfp_pkg::POS_MD_LO): cap_in.md[7:0]  = req_rx_byte;
               PW'(rrfp_pkg::POS_MD_HI): cap_in.md[15:8] = req_rx_byte;
               PW'(rrfp_pkg::POS_ME):    cap_in.me       = req_rx_byte;
               PW'(rrfp_pkg::POS_SD_LO): cap_in.sd[7:0]  = req_rx_byte;
               PW'(rrfp_pkg::POS_SD_HI): cap_in.sd[15:8] = req_rx_byte;
               PW'(rrfp_pkg::POS_SE):    cap_in.se       = req_rx_byte;
               PW'(rrfp_pkg::POS_MGATE): cap_in.mgate    = req_rx_byte;
               PW'(rrfp_pkg::POS_SGATE): cap_in.sgate    = req_rx_byte;
               PW'(rrfp_pkg::POS_LIGHT): cap_in.light    = req_rx_byte;
               default: ;
            endcase

            // tail marker and footer, relative to the frame end
            if (pos_ff == exp_ff - PW'(6)) begin
               mark_ok_in = (req_rx_byte == rrfp_pkg::MARK_TAIL);
            end
            if (pos_ff == exp_ff - PW'(4)) begin
               foot_ok_in = (req_rx_byte == rrfp_pkg::FTR_0);
            end else if (pos_ff == exp_ff - PW'(3)) begin
               foot_ok_in = foot_ok_ff & (req_rx_byte == rrfp_pkg::FTR_1);
            end else if (pos_ff == exp_ff - PW'(2)) begin
               foot_ok_in = foot_ok_ff & (req_rx_byte == rrfp_pkg::FTR_2);
            end

            if (pos_ff == PW'(rrfp_pkg::POS_LEN_HI)) begin
               // length check
               if (plen < 16'(rrfp_pkg::MIN_PAYLOAD) || plen_total > LEN_LIMIT) begin
                  ev_valid         = 1'b1;
                  ev_data.rejected = 1'b1;
                  pos_in           = '0;
                  exp_in           = '0;
               end else begin
                  exp_in = plen_total[PW-1:0];
               end
            end else if (pos_in == exp_ff) begin
               // last byte of the frame
               ev_valid         = 1'b1;
               ev_data.rejected = ~frame_ok;
               ev_data.eng      = eng_ff;
               ev_data.wide     = eng_ff & (exp_ff >= WIDE_LEN);
               pos_in           = '0;
               exp_in           = '0;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         exp_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         exp_ff <= exp_in;
      end
   end

   // captured fields and check flags
   always_ff @(posedge clock) begin
      len_lo_ff  <= len_lo_in;
      type_ok_ff <= type_ok_in;
      eng_ff     <= eng_in;
      head_ok_ff <= head_ok_in;
      mark_ok_ff <= mark_ok_in;
      foot_ok_ff <= foot_ok_in;
      cap_ff     <= cap_in;
   end

endmodule

@@ rtl/rrfp_queue.sv @@
// rrfp_queue: short fifo of frame events between the front and the back
// depends on rrfp_pkg
module rrfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  rrfp_pkg::event_type   push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output rrfp_pkg::event_type   pop_data
);

   localparam int AW = rrfp_pkg::QUEUE_AW;
   localparam int CW = rrfp_pkg::QUEUE_CW;

   rrfp_pkg::event_type mem_ff [rrfp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (count_ff == CW'(rrfp_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      do_push   = push_valid & ~full;
      do_pop    = pop & pop_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/rrfp_back.sv @@
// rrfp_back: turns frame events into result transactions, keeps the valid
// and invalid frame counters and picks the target distance
// depends on rrfp_pkg
module rrfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  rrfp_pkg::event_type   ev_data,
   output logic                  ev_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic                  rsp_engineering_mode,
   output logic [7:0]            rsp_target_state,
   output logic [15:0]           rsp_moving_distance,
   output logic [7:0]            rsp_moving_energy,
   output logic [15:0]           rsp_static_distance,
   output logic [7:0]            rsp_static_energy,
   output logic [15:0]           rsp_target_distance,
   output logic [7:0]            rsp_max_moving_gate,
   output logic [7:0]            rsp_max_static_gate,
   output logic [7:0]            rsp_light_level,
   output logic [31:0]           rsp_frame_count
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] valid_cnt_ff, valid_cnt_in;
   logic [31:0] invalid_cnt_ff, invalid_cnt_in;
   logic        kind_ff, kind_in;
   logic        eng_ff, eng_in;
   logic [7:0]  state_ff, state_in;
   logic [15:0] md_ff, md_in;
   logic [7:0]  me_ff, me_in;
   logic [15:0] sd_ff, sd_in;
   logic [7:0]  se_ff, se_in;
   logic [15:0] td_ff, td_in;
   logic [7:0]  mgate_ff, mgate_in;
   logic [7:0]  sgate_ff, sgate_in;
   logic [7:0]  light_ff, light_in;
   logic [31:0] count_ff, count_in;

   logic        load;
   logic        has_moving;
   logic        has_static;
   logic [15:0] td;

   // target distance selection
   always_comb begin
      has_moving = ev_data.state[0];
      has_static = ev_data.state[1];
      td         = '0;
      if (has_moving && has_static) begin
         if (ev_data.md == '0) begin
            td = ev_data.sd;
         end else if (ev_data.sd == '0) begin
            td = ev_data.md;
         end else begin
            td = (ev_data.md < ev_data.sd) ? ev_data.md : ev_data.sd;
         end
      end else if (has_moving) begin
         td = ev_data.md;
      end else if (has_static) begin
         td = ev_data.sd;
      end
   end

   // result build and output register
   always_comb begin
      load           = ev_valid & (~rsp_valid_ff | ~rsp_stall);
      ev_pop         = load;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      valid_cnt_in   = valid_cnt_ff;
      invalid_cnt_in = invalid_cnt_ff;
      kind_in        = kind_ff;
      eng_in         = eng_ff;
      state_in       = state_ff;
      md_in          = md_ff;
      me_in          = me_ff;
      sd_in          = sd_ff;
      se_in          = se_ff;
      td_in          = td_ff;
      mgate_in       = mgate_ff;
      sgate_in       = sgate_ff;
      light_in       = light_ff;
      count_in       = count_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (ev_data.rejected) begin
            invalid_cnt_in = invalid_cnt_ff + 32'd1;
            kind_in        = 1'b1;
            eng_in         = 1'b0;
            state_in       = '0;
            md_in          = '0;
            me_in          = '0;
            sd_in          = '0;
            se_in          = '0;
            td_in          = '0;
            mgate_in       = '0;
            sgate_in       = '0;
            light_in       = '0;
            count_in       = invalid_cnt_ff + 32'd1;
         end else begin
            valid_cnt_in = valid_cnt_ff + 32'd1;
            kind_in      = 1'b0;
            eng_in       = ev_data.eng;
            state_in     = ev_data.state;
            md_in        = ev_data.md;
            me_in        = ev_data.me;
            sd_in        = ev_data.sd;
            se_in        = ev_data.se;
            td_in        = td;
            mgate_in     = ev_data.wide ? ev_data.mgate : '0;
            sgate_in     = ev_data.wide ? ev_data.sgate : '0;
            light_in     = ev_data.wide ? ev_data.light : '0;
            count_in     = valid_cnt_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         valid_cnt_ff   <= '0;
         invalid_cnt_ff <= '0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         valid_cnt_ff   <= valid_cnt_in;
         invalid_cnt_ff <= invalid_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      eng_ff   <= eng_in;
      state_ff <= state_in;
      md_ff    <= md_in;
      me_ff    <= me_in;
      sd_ff    <= sd_in;
      se_ff    <= se_in;
      td_ff    <= td_in;
      mgate_ff <= mgate_in;
      sgate_ff <= sgate_in;
      light_ff <= light_in;
      count_ff <= count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_engineering_mode = eng_ff;
   assign rsp_target_state     = state_ff;
   assign rsp_moving_distance  = md_ff;
   assign rsp_moving_energy    = me_ff;
   assign rsp_static_distance  = sd_ff;
   assign rsp_static_energy    = se_ff;
   assign rsp_target_distance  = td_ff;
   assign rsp_max_moving_gate  = mgate_ff;
   assign rsp_max_static_gate  = sgate_ff;
   assign rsp_light_level      = light_ff;
   assign rsp_frame_count      = count_ff;

endmodule

@@ rtl/radar_report_frame_parser.sv @@
// radar_report_frame_parser: one received byte per transaction, one byte per
// cycle while req_stall is low; the front framer decides each byte in its
// accept cycle. A result is offered on rsp_valid after the frame's last byte
// is accepted, via the event queue write, then the back end output register.
// req_stall rises only when the four-entry event queue is full.
// synchronous active-high reset clears the framer, queue, counters and rsp_valid.
module radar_report_frame_parser #(
   parameter int FRAME_BYTES = rrfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic        rsp_engineering_mode,
   output logic [7:0]  rsp_target_state,
   output logic [15:0] rsp_moving_distance,
   output logic [7:0]  rsp_moving_energy,
   output logic [15:0] rsp_static_distance,
   output logic [7:0]  rsp_static_energy,
   output logic [15:0] rsp_target_distance,
   output logic [7:0]  rsp_max_moving_gate,
   output logic [7:0]  rsp_max_static_gate,
   output logic [7:0]  rsp_light_level,
   output logic [31:0] rsp_frame_count
);

   logic                q_full;
   logic                push_valid;
   rrfp_pkg::event_type push_data;
   logic                pop;
   logic                pop_valid;
   rrfp_pkg::event_type pop_data;

   // byte framer
   rrfp_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (q_full),
      .ev_valid    (push_valid),
      .ev_data     (push_data)
   );

   // event queue
   rrfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // report builder
   rrfp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .ev_valid             (pop_valid),
      .ev_data              (pop_data),
      .ev_pop               (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_engineering_mode (rsp_engineering_mode),
      .rsp_target_state     (rsp_target_state),
      .rsp_moving_distance  (rsp_moving_distance),
      .rsp_moving_energy    (rsp_moving_energy),
      .rsp_static_distance  (rsp_static_distance),
      .rsp_static_energy    (rsp_static_energy),
      .rsp_target_distance  (rsp_target_distance),
      .rsp_max_moving_gate  (rsp_max_moving_gate),
      .rsp_max_static_gate  (rsp_max_static_gate),
      .rsp_light_level      (rsp_light_level),
      .rsp_frame_count      (rsp_frame_count)
   );

endmodule
